FILE: rtl/mlft_pkg.sv
// ----------------------------------------------------------------------------
// mlft_pkg
// Shared widths, table size, payload structs and engine states for the
// learning forwarding table.
// ----------------------------------------------------------------------------
package mlft_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	localparam int MAC_W  = 48;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_W  = 32;

	localparam logic [CFG_W-1:0] AGE_LIMIT_RST = 32'd300;

	// header queue between front and engine
	localparam int HQ_DEPTH = 2;
	localparam int HQ_PTR_W = $clog2(HQ_DEPTH);
	localparam int HQ_CNT_W = $clog2(HQ_DEPTH + 1);

	// result queue at the output
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [MAC_W-1:0]  dest_mac;
		logic [MAC_W-1:0]  source_mac;
		logic [IP_W-1:0]   sender_ip;
		logic [PORT_W-1:0] sender_port;
		logic [TIME_W-1:0] now;
		logic              self_dst;
	} hdr_t;

	typedef struct packed {
		logic [IP_W-1:0]   out_ip;
		logic [PORT_W-1:0] out_port;
		logic              flooded;
		logic              learn_failed;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] stamp;
	} slot_data_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEARN,
		ST_LOOKUP,
		ST_WALK,
		ST_DRAIN
	} eng_state_t;

endpackage

FILE: rtl/mlft_if.sv
// ----------------------------------------------------------------------------
// mlft_if
// Valid/ready channels for frame headers and forwarding results.
// ----------------------------------------------------------------------------
interface mlft_hdr_if;
	logic        valid;
	logic        ready;
	logic [47:0] dest_mac;
	logic [47:0] source_mac;
	logic [31:0] sender_ip;
	logic [15:0] sender_port;
	logic [31:0] now;

	modport source (
		output valid, dest_mac, source_mac, sender_ip, sender_port, now,
		input  ready
	);
	modport sink (
		input  valid, dest_mac, source_mac, sender_ip, sender_port, now,
		output ready
	);
endinterface

interface mlft_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_ip;
	logic [15:0] out_port;
	logic        flooded;
	logic        learn_failed;
	logic        last;

	modport source (
		output valid, out_ip, out_port, flooded, learn_failed, last,
		input  ready
	);
	modport sink (
		input  valid, out_ip, out_port, flooded, learn_failed, last,
		output ready
	);
endinterface

FILE: rtl/mlft_front.sv
// ----------------------------------------------------------------------------
// mlft_front
// Takes frame header beats, flags frames sent back to their own source and
// holds them in a short queue for the table engine.
// ----------------------------------------------------------------------------
module mlft_front (
	input  logic          clk,
	input  logic          arst_n,
	mlft_hdr_if.sink      hdr,
	output mlft_pkg::hdr_t head,
	output logic          head_valid,
	input  logic          pop
);
	import mlft_pkg::*;

	hdr_t                fifo_q [HQ_DEPTH];
	logic [HQ_PTR_W-1:0] wr_ptr_q;
	logic [HQ_PTR_W-1:0] rd_ptr_q;
	logic [HQ_CNT_W-1:0] count_q;
	logic                push;
	hdr_t                in_hdr;

	assign hdr.ready  = (count_q != HQ_CNT_W'(HQ_DEPTH));
	assign push       = hdr.valid && hdr.ready;
	assign head_valid = (count_q != '0);
	assign head       = fifo_q[rd_ptr_q];

	always_comb begin
		in_hdr.dest_mac    = hdr.dest_mac;
		in_hdr.source_mac  = hdr.source_mac;
		in_hdr.sender_ip   = hdr.sender_ip;
		in_hdr.sender_port = hdr.sender_port;
		in_hdr.now         = hdr.now;
		// destination is the sender itself: engine can reuse the learned slot
		in_hdr.self_dst    = (hdr.dest_mac == hdr.source_mac);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + HQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + HQ_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + HQ_CNT_W'(1);
				2'b01:   count_q <= count_q - HQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/mlft_outq.sv
// ----------------------------------------------------------------------------
// mlft_outq
// Result queue between the table engine and the result channel.
// ----------------------------------------------------------------------------
module mlft_outq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  mlft_pkg::res_t           push_data,
	output logic [mlft_pkg::OQ_CNT_W-1:0] count,
	mlft_res_if.source               res
);
	import mlft_pkg::*;

	res_t                fifo_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;
	res_t                head;

	assign count     = count_q;
	assign head      = fifo_q[rd_ptr_q];
	assign res.valid = (count_q != '0);
	assign pop       = res.valid && res.ready;

	assign res.out_ip       = head.out_ip;
	assign res.out_port     = head.out_port;
	assign res.flooded      = head.flooded;
	assign res.learn_failed = head.learn_failed;
	assign res.last         = head.last;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + OQ_CNT_W'(1);
				2'b01:   count_q <= count_q - OQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/mlft_back.sv
// ----------------------------------------------------------------------------
// mlft_back
// Table engine: learns the source, looks up the destination, walks the
// valid slots for a flood and ages out entries it has sent to.
// ----------------------------------------------------------------------------
module mlft_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlft_pkg::hdr_t                head,
	input  logic                          head_valid,
	output logic                          pop,
	input  logic [mlft_pkg::CFG_W-1:0]    age_limit,
	output logic                          push,
	output mlft_pkg::res_t                push_data,
	input  logic [mlft_pkg::OQ_CNT_W-1:0] oq_count
);
	import mlft_pkg::*;

	function automatic logic [IDX_W-1:0] first_idx(input logic [TABLE_DEPTH-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	eng_state_t state_q, state_d;

	// lookup side: mac and valid in flops, compared in parallel
	logic [MAC_W-1:0]       mac_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	// address, port and stamp in a single-port-read table
	slot_data_t             ram_q [TABLE_DEPTH];

	hdr_t                   hdr_q;
	logic                   failed_q;
	logic [IDX_W-1:0]       learn_slot_q;
	logic [TABLE_DEPTH-1:0] pend_q;

	slot_data_t             rd_data_s1;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_slot_s1;
	logic                   rd_flood_s1;
	logic                   rd_last_s1;

	logic [TABLE_DEPTH-1:0] src_match;
	logic [TABLE_DEPTH-1:0] dst_match;
	logic                   src_hit;
	logic                   free_hit;
	logic [IDX_W-1:0]       learn_slot;
	logic                   dst_hit;
	logic [IDX_W-1:0]       dst_slot;
	logic [TABLE_DEPTH-1:0] pend_rest;
	logic [IDX_W-1:0]       pend_idx;
	logic [OQ_CNT_W-1:0]    occupancy;
	logic                   room;
	logic [TIME_W-1:0]      age;
	logic                   aged;

	logic                   learn_we;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   rd_flood;
	logic                   rd_last;
	logic                   pend_load;
	logic                   pend_step;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			src_match[i] = valid_q[i] && (mac_q[i] == hdr_q.source_mac);
			dst_match[i] = valid_q[i] && (mac_q[i] == hdr_q.dest_mac);
		end
	end

	assign src_hit    = |src_match;
	assign free_hit   = ~&valid_q;
	assign learn_slot = src_hit ? first_idx(src_match) : first_idx(~valid_q);

	// a frame to its own source hits the slot just learned, if learning worked
	assign dst_hit  = (hdr_q.self_dst && !failed_q) || (|dst_match);
	assign dst_slot = (hdr_q.self_dst && !failed_q) ? learn_slot_q : first_idx(dst_match);

	assign pend_rest = pend_q & (pend_q - TABLE_DEPTH'(1));
	assign pend_idx  = first_idx(pend_q);

	// count the read in flight so the result queue never overflows
	assign occupancy = oq_count + {{(OQ_CNT_W-1){1'b0}}, rd_vld_s1};
	assign room      = (occupancy < OQ_CNT_W'(OQ_DEPTH));

	assign age  = hdr_q.now - rd_data_s1.stamp;
	assign aged = (age > age_limit);

	assign push                   = rd_vld_s1;
	assign push_data.out_ip       = rd_data_s1.ip;
	assign push_data.out_port     = rd_data_s1.port;
	assign push_data.flooded      = rd_flood_s1;
	assign push_data.learn_failed = failed_q;
	assign push_data.last         = rd_last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		learn_we  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = dst_slot;
		rd_flood  = 1'b0;
		rd_last   = 1'b0;
		pend_load = 1'b0;
		pend_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = ST_LEARN;
				end
			end
			ST_LEARN: begin
				learn_we = src_hit || free_hit;
				state_d  = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (dst_hit) begin
					if (room) begin
						rd_en   = 1'b1;
						rd_addr = dst_slot;
						rd_last = 1'b1;
						state_d = ST_DRAIN;
					end
				end else if (valid_q == '0) begin
					state_d = ST_DRAIN;
				end else begin
					pend_load = 1'b1;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				if (room) begin
					rd_en     = 1'b1;
					rd_addr   = pend_idx;
					rd_flood  = 1'b1;
					rd_last   = (pend_rest == '0);
					pend_step = 1'b1;
					if (pend_rest == '0) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				// let the last read age its entry before the next frame learns
				if (!rd_vld_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (learn_we) begin
				valid_q[learn_slot] <= 1'b1;
			end
			if (rd_vld_s1 && aged) begin
				valid_q[rd_slot_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hdr_q <= head;
		end
		if (state_q == ST_LEARN) begin
			failed_q     <= !(src_hit || free_hit);
			learn_slot_q <= learn_slot;
		end
		if (learn_we) begin
			mac_q[learn_slot] <= hdr_q.source_mac;
			ram_q[learn_slot] <= '{ip: hdr_q.sender_ip, port: hdr_q.sender_port,
				stamp: hdr_q.now};
		end
		if (pend_load) begin
			pend_q <= valid_q;
		end else if (pend_step) begin
			pend_q <= pend_rest;
		end
		if (rd_en) begin
			rd_data_s1  <= ram_q[rd_addr];
			rd_slot_s1  <= rd_addr;
			rd_flood_s1 <= rd_flood;
			rd_last_s1  <= rd_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (oq_count < OQ_CNT_W'(OQ_DEPTH)))
		else $error("result queue written while full");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_vld_s1)
		else $error("read still in flight when engine went idle");

	a_walk_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (pend_q != '0))
		else $error("flood walk with no slot left to send");

	a_unicast_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && !rd_flood_s1) |-> rd_last_s1)
		else $error("unicast result not marked last");

	a_learn_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEARN) |=> (state_q == ST_LOOKUP))
		else $error("learn step not followed by lookup");
`endif

endmodule

FILE: rtl/mac_learning_forward_table_unit.sv
// ----------------------------------------------------------------------------
// mac_learning_forward_table_unit: learning forwarding table with aging
// The first result passes the header queue, the learn and lookup states and the table read.
// One frame at a time; floods give one result per cycle while the result queue has room.
// Reset clears all valid bits, sets age_limit to 300; slot contents undefined.
// ----------------------------------------------------------------------------
module mac_learning_forward_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	mlft_hdr_if.sink                   hdr,
	mlft_res_if.source                 res,
	input  logic                       cfg_we,
	input  logic [mlft_pkg::CFG_W-1:0] cfg_wdata
);
	import mlft_pkg::*;

	logic [CFG_W-1:0]    age_limit_q;
	hdr_t                head;
	logic                head_valid;
	logic                pop;
	logic                push;
	res_t                push_data;
	logic [OQ_CNT_W-1:0] oq_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RST;
		end else if (cfg_we) begin
			age_limit_q <= cfg_wdata;
		end
	end

	mlft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr        (hdr),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	mlft_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.age_limit  (age_limit_q),
		.push       (push),
		.push_data  (push_data),
		.oq_count   (oq_count)
	);

	mlft_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (oq_count),
		.res       (res)
	);

endmodule
